@@ src/qvr_pkg.sv @@
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared widths, status codes and word types of the quadratic solver.
// ----------------------------------------------------------------------------
package qvr_pkg;

    localparam int CW  = 16;             // coefficient width
    localparam int FB  = 16;             // fractional bits of every result
    localparam int OW  = 48;             // result field width
    localparam int DW  = 2 * CW + 2;     // discriminant magnitude width
    localparam int SW  = CW + 1 + FB;    // square root width
    localparam int RW  = 2 * SW;         // radicand width
    localparam int RNW = SW + 2;         // root numerator width
    localparam int VXN = CW + FB;        // vertex x numerator width
    localparam int VYN = DW + FB;        // vertex y numerator width
    localparam int LAT = SW + 1 + RNW;   // back pipeline depth

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_DOUBLE = 2'd1,
        ST_TWO    = 2'd2,
        ST_A_ZERO = 2'd3
    } status_t;

    // classified word, front to back
    typedef struct packed {
        status_t        status;
        logic           a_neg;
        logic [CW-1:0]  a_mag;
        logic           b_neg;
        logic [CW-1:0]  b_mag;
        logic [DW-1:0]  d_mag;
        logic           vx_neg;
        logic           vy_neg;
    } item_t;

    typedef struct packed {
        logic [OW-1:0]  vertex_x;
        logic [OW-1:0]  vertex_y;
        status_t        root_status;
        logic [OW-1:0]  root_first;
        logic [OW-1:0]  root_second;
    } result_t;

endpackage

@@ src/quadratic_vertex_and_roots.sv @@
// ----------------------------------------------------------------------------
// quadratic_vertex_and_roots
// Vertex and real roots of a*x^2+b*x+c, signed fixed point results.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  input     s_coef_a, s_coef_b, s_coef_c            s_valid / s_ready
//  result    m_vertex_x, m_vertex_y, m_root_status,  m_valid / m_ready
//            m_root_first, m_root_second
//
//  One word per cycle sustained while m_ready holds. Path: input register,
//  queue, 33 square root stages, one sum stage, 35 root divider stages and
//  the output queue. The root divider after the square root sets the depth.
//  Synchronous active-low reset clears valid state only.
//  A full output queue freezes the back pipeline; the front keeps filling
//  its two-word queue meanwhile.
// ----------------------------------------------------------------------------
module quadratic_vertex_and_roots import qvr_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [CW-1:0] s_coef_a,
    input  logic [CW-1:0] s_coef_b,
    input  logic [CW-1:0] s_coef_c,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [OW-1:0] m_vertex_x,
    output logic [OW-1:0] m_vertex_y,
    output logic [1:0]    m_root_status,
    output logic [OW-1:0] m_root_first,
    output logic [OW-1:0] m_root_second
);

    logic    f_valid, f_ready, q_valid, q_ready;
    item_t   f_item, q_item;
    result_t res;

    qvr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_coef_a  (s_coef_a),
        .s_coef_b  (s_coef_b),
        .s_coef_c  (s_coef_c),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    qvr_fifo2 #(.data_t(item_t)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_item)
    );

    qvr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (res)
    );

    assign m_vertex_x    = res.vertex_x;
    assign m_vertex_y    = res.vertex_y;
    assign m_root_status = res.root_status;
    assign m_root_first  = res.root_first;
    assign m_root_second = res.root_second;

endmodule

@@ src/qvr_front.sv @@
// ----------------------------------------------------------------------------
// qvr_front
// Registers a coefficient word, forms the discriminant and classifies it.
// ----------------------------------------------------------------------------
module qvr_front import qvr_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [CW-1:0] s_coef_a,
    input  logic [CW-1:0] s_coef_b,
    input  logic [CW-1:0] s_coef_c,
    output logic          out_valid,
    input  logic          out_ready,
    output item_t         out_item
);

    logic          f_valid_reg, f_valid_next;
    logic [CW-1:0] a_reg, b_reg, c_reg;
    logic          accept;

    logic          a_neg, b_neg, c_neg, opp, d_neg, d_zero;
    logic [CW-1:0] a_mag, b_mag, c_mag;
    logic [2*CW-1:0] bsq, prod;
    logic [DW-1:0] bsq_e, p4, d_mag;

    assign s_ready   = !f_valid_reg || out_ready;
    assign accept    = s_valid && s_ready;
    assign out_valid = f_valid_reg;

    always_comb begin
        f_valid_next = accept || (f_valid_reg && !out_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_reg <= s_coef_a;
            b_reg <= s_coef_b;
            c_reg <= s_coef_c;
        end
    end

    always_comb begin
        a_neg = a_reg[CW-1];
        b_neg = b_reg[CW-1];
        c_neg = c_reg[CW-1];
        a_mag = a_neg ? (~a_reg + 1'b1) : a_reg;
        b_mag = b_neg ? (~b_reg + 1'b1) : b_reg;
        c_mag = c_neg ? (~c_reg + 1'b1) : c_reg;
        bsq   = b_mag * b_mag;
        prod  = a_mag * c_mag;
        bsq_e = {2'b00, bsq};
        p4    = {prod, 2'b00};
        opp   = (prod != '0) && (a_neg != c_neg);
        // delta = b^2 - 4ac as sign and magnitude
        if (opp) begin
            d_neg = 1'b0;
            d_mag = bsq_e + p4;
        end else if (p4 > bsq_e) begin
            d_neg = 1'b1;
            d_mag = p4 - bsq_e;
        end else begin
            d_neg = 1'b0;
            d_mag = bsq_e - p4;
        end
        d_zero = (d_mag == '0);

        priority if (a_mag == '0) begin
            out_item.status = ST_A_ZERO;
        end else if (d_neg) begin
            out_item.status = ST_NONE;
        end else if (d_zero) begin
            out_item.status = ST_DOUBLE;
        end else begin
            out_item.status = ST_TWO;
        end
        out_item.a_neg  = a_neg;
        out_item.a_mag  = a_mag;
        out_item.b_neg  = b_neg;
        out_item.b_mag  = b_mag;
        out_item.d_mag  = d_mag;
        out_item.vx_neg = ((!b_neg) && (b_mag != '0)) != a_neg;
        out_item.vy_neg = (!d_zero) && ((!d_neg) != a_neg);
    end

endmodule

@@ src/qvr_fifo2.sv @@
// ----------------------------------------------------------------------------
// qvr_fifo2
// Two-entry queue; ready depends on registered fill only.
// ----------------------------------------------------------------------------
module qvr_fifo2 #(
    parameter type data_t = logic
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  data_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output data_t out_data
);

    data_t      data_reg [0:1];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = data_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

@@ src/qvr_div.sv @@
// ----------------------------------------------------------------------------
// qvr_div
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qvr_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 17
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo
);

    // numerator drains from the top while quotient bits fill the bottom
    logic [NUM_W-1:0] num_reg [1:NUM_W];
    logic [DEN_W-1:0] rem_reg [1:NUM_W-1];
    logic [DEN_W-1:0] den_reg [1:NUM_W-1];

    for (genvar k = 1; k <= NUM_W; k++) begin : g_stage
        logic [NUM_W-1:0] n_in;
        logic [DEN_W-1:0] r_in, d_in;
        logic [DEN_W:0]   trial;
        logic             take;

        if (k == 1) begin : g_first
            assign n_in = num;
            assign r_in = '0;
            assign d_in = den;
        end else begin : g_next
            assign n_in = num_reg[k-1];
            assign r_in = rem_reg[k-1];
            assign d_in = den_reg[k-1];
        end

        always_comb begin
            trial = {r_in, n_in[NUM_W-1]};
            take  = (trial >= {1'b0, d_in});
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[k] <= {n_in[NUM_W-2:0], take};
            end
        end

        if (k < NUM_W) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= take ? DEN_W'(trial - {1'b0, d_in}) : DEN_W'(trial);
                    den_reg[k] <= d_in;
                end
            end
        end
    end

    assign quo = num_reg[NUM_W];

endmodule

@@ src/qvr_back.sv @@
// ----------------------------------------------------------------------------
// qvr_back
// Square root and division pipeline; assembles result words.
// ----------------------------------------------------------------------------
module qvr_back import qvr_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   in_item,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    localparam int VXD = LAT - VXN;
    localparam int VYD = LAT - VYN;

    typedef struct packed {
        status_t       status;
        logic          a_neg;
        logic [CW-1:0] a_mag;
        logic          b_neg;
        logic [CW-1:0] b_mag;
        logic          vx_neg;
        logic          vy_neg;
    } ctl_t;

    logic    en, ob_ready;
    ctl_t    ctl_in;
    ctl_t    ctl_reg [1:LAT];
    logic    v_reg [1:LAT];
    result_t res;

    // whole pipeline moves while the output queue has room
    assign en       = ob_ready;
    assign in_ready = en;

    always_comb begin
        ctl_in.status = in_item.status;
        ctl_in.a_neg  = in_item.a_neg;
        ctl_in.a_mag  = in_item.a_mag;
        ctl_in.b_neg  = in_item.b_neg;
        ctl_in.b_mag  = in_item.b_mag;
        ctl_in.vx_neg = in_item.vx_neg;
        ctl_in.vy_neg = in_item.vy_neg;
    end

    for (genvar k = 1; k <= LAT; k++) begin : g_ctl
        logic v_in;
        ctl_t c_in;
        if (k == 1) begin : g_first
            assign v_in = in_valid;
            assign c_in = ctl_in;
        end else begin : g_next
            assign v_in = v_reg[k-1];
            assign c_in = ctl_reg[k-1];
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                ctl_reg[k] <= c_in;
            end
        end
    end

    // square root of delta << 2*FB, one root bit per stage
    logic [RW-1:0] sq_rad_reg  [1:SW-1];
    logic [SW:0]   sq_rem_reg  [1:SW-1];
    logic [SW-1:0] sq_root_reg [1:SW];

    for (genvar j = 1; j <= SW; j++) begin : g_sqrt
        logic [RW-1:0] rad_in;
        logic [SW:0]   rem_in;
        logic [SW-1:0] root_in;
        logic [SW+2:0] rem_ext, trial;
        logic          ge;

        if (j == 1) begin : g_first
            assign rad_in  = RW'(in_item.d_mag) << (2 * FB);
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign rad_in  = sq_rad_reg[j-1];
            assign rem_in  = sq_rem_reg[j-1];
            assign root_in = sq_root_reg[j-1];
        end

        always_comb begin
            rem_ext = {rem_in, rad_in[RW-1:RW-2]};
            trial   = {1'b0, root_in, 2'b01};
            ge      = (rem_ext >= trial);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_root_reg[j] <= {root_in[SW-2:0], ge};
            end
        end

        if (j < SW) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    sq_rad_reg[j] <= rad_in << 2;
                    sq_rem_reg[j] <= ge ? (SW+1)'(rem_ext - trial) : (SW+1)'(rem_ext);
                end
            end
        end
    end

    // root numerators -b*2^FB -/+ s
    logic [RNW-1:0] nb_mag, nb, s_e;
    logic [RNW-1:0] n1_reg, n2_reg;
    logic [RNW-1:0] mag1, mag2;
    logic [RNW-1:0] r1_quo, r2_quo;
    logic [1:0]     rsg_reg [1:RNW];

    always_comb begin
        nb_mag = RNW'(ctl_reg[SW].b_mag) << FB;
        nb     = ctl_reg[SW].b_neg ? nb_mag : (~nb_mag + 1'b1);
        s_e    = RNW'(sq_root_reg[SW]);
        mag1   = n1_reg[RNW-1] ? (~n1_reg + 1'b1) : n1_reg;
        mag2   = n2_reg[RNW-1] ? (~n2_reg + 1'b1) : n2_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n1_reg <= nb - s_e;
            n2_reg <= nb + s_e;
        end
    end

    for (genvar k = 1; k <= RNW; k++) begin : g_rsg
        logic [1:0] s_in;
        if (k == 1) begin : g_first
            assign s_in = {n1_reg[RNW-1], n2_reg[RNW-1]};
        end else begin : g_next
            assign s_in = rsg_reg[k-1];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rsg_reg[k] <= s_in;
            end
        end
    end

    qvr_div #(.NUM_W(RNW), .DEN_W(CW + 1)) u_div_r1 (
        .aclk (aclk),
        .en   (en),
        .num  (mag1),
        .den  ({ctl_reg[SW+1].a_mag, 1'b0}),
        .quo  (r1_quo)
    );

    qvr_div #(.NUM_W(RNW), .DEN_W(CW + 1)) u_div_r2 (
        .aclk (aclk),
        .en   (en),
        .num  (mag2),
        .den  ({ctl_reg[SW+1].a_mag, 1'b0}),
        .quo  (r2_quo)
    );

    // vertex quotients start at once and wait in delay lines
    logic [VXN-1:0] vx_quo;
    logic [VYN-1:0] vy_quo;
    logic [VXN-1:0] vxd_reg [1:VXD];
    logic [VYN-1:0] vyd_reg [1:VYD];

    qvr_div #(.NUM_W(VXN), .DEN_W(CW + 1)) u_div_vx (
        .aclk (aclk),
        .en   (en),
        .num  (VXN'(in_item.b_mag) << FB),
        .den  ({in_item.a_mag, 1'b0}),
        .quo  (vx_quo)
    );

    qvr_div #(.NUM_W(VYN), .DEN_W(CW + 2)) u_div_vy (
        .aclk (aclk),
        .en   (en),
        .num  (VYN'(in_item.d_mag) << FB),
        .den  ({in_item.a_mag, 2'b00}),
        .quo  (vy_quo)
    );

    for (genvar k = 1; k <= VXD; k++) begin : g_vxd
        logic [VXN-1:0] x_in;
        if (k == 1) begin : g_first
            assign x_in = vx_quo;
        end else begin : g_next
            assign x_in = vxd_reg[k-1];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                vxd_reg[k] <= x_in;
            end
        end
    end

    for (genvar k = 1; k <= VYD; k++) begin : g_vyd
        logic [VYN-1:0] y_in;
        if (k == 1) begin : g_first
            assign y_in = vy_quo;
        end else begin : g_next
            assign y_in = vyd_reg[k-1];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                vyd_reg[k] <= y_in;
            end
        end
    end

    // result assembly
    logic [OW-1:0] vx_e, vy_e, r1_e, r2_e;
    logic [OW-1:0] vx_val, vy_val, r1_val, r2_val;
    ctl_t          c_end;

    always_comb begin
        c_end  = ctl_reg[LAT];
        vx_e   = OW'(vxd_reg[VXD]);
        vy_e   = OW'(vyd_reg[VYD]);
        r1_e   = OW'(r1_quo);
        r2_e   = OW'(r2_quo);
        vx_val = c_end.vx_neg ? (~vx_e + 1'b1) : vx_e;
        vy_val = c_end.vy_neg ? (~vy_e + 1'b1) : vy_e;
        r1_val = (rsg_reg[RNW][1] != c_end.a_neg) ? (~r1_e + 1'b1) : r1_e;
        r2_val = (rsg_reg[RNW][0] != c_end.a_neg) ? (~r2_e + 1'b1) : r2_e;

        res.root_status = c_end.status;
        unique case (c_end.status)
            ST_A_ZERO: begin
                res.vertex_x    = '0;
                res.vertex_y    = '0;
                res.root_first  = '0;
                res.root_second = '0;
            end
            ST_NONE: begin
                res.vertex_x    = vx_val;
                res.vertex_y    = vy_val;
                res.root_first  = '0;
                res.root_second = '0;
            end
            ST_DOUBLE: begin
                res.vertex_x    = vx_val;
                res.vertex_y    = vy_val;
                res.root_first  = vx_val;
                res.root_second = vx_val;
            end
            default: begin
                res.vertex_x    = vx_val;
                res.vertex_y    = vy_val;
                res.root_first  = r1_val;
                res.root_second = r2_val;
            end
        endcase
    end

    qvr_fifo2 #(.data_t(result_t)) u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (en && v_reg[LAT]),
        .in_ready  (ob_ready),
        .in_data   (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_res)
    );

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for quadratic_vertex_and_roots: a driver streams
// coefficient sets and a monitor checks every result word against a
// behavioral predictor, with random idle and stall phases.
// ----------------------------------------------------------------------------
module tb;
    import qvr_pkg::*;

    typedef struct packed {
        logic [CW-1:0] a;
        logic [CW-1:0] b;
        logic [CW-1:0] c;
    } coefs_t;

    localparam int CYCLE_LIMIT = 400000;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic [CW-1:0] s_coef_a = '0;
    logic [CW-1:0] s_coef_b = '0;
    logic [CW-1:0] s_coef_c = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic [OW-1:0] m_vertex_x;
    logic [OW-1:0] m_vertex_y;
    logic [1:0]    m_root_status;
    logic [OW-1:0] m_root_first;
    logic [OW-1:0] m_root_second;

    coefs_t  coef_queue[$];
    result_t solution_queue[$];
    int      src_idle_pct = 0;
    int      snk_stall_pct = 0;
    int      n_errors = 0;
    int      n_solved = 0;
    int      hold_left = 0;
    bit      hold_done = 1'b0;
    longint  cycles = 0;

    quadratic_vertex_and_roots uut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic longint isqrt128(logic [127:0] v);
        logic [127:0] root;
        logic [127:0] rem;
        logic [127:0] trial;
        root = '0;
        rem = '0;
        for (int p = 63; p >= 0; p--) begin
            rem = (rem << 2) | v[2*p +: 2];
            trial = (root << 2) | 1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 1;
            end else begin
                root = root << 1;
            end
        end
        return longint'(root);
    endfunction

    function automatic result_t solve_quadratic(coefs_t w);
        result_t r;
        longint a, b, c, disc, nb, two_a, s;
        logic [127:0] rad;
        a = longint'($signed(w.a));
        b = longint'($signed(w.b));
        c = longint'($signed(w.c));
        r = '0;
        if (a == 0) begin
            r.root_status = ST_A_ZERO;
            return r;
        end
        disc = b * b - 4 * a * c;
        nb = -b * 65536;
        two_a = 2 * a;
        r.vertex_x = OW'(nb / two_a);
        r.vertex_y = OW'((-disc * 65536) / (4 * a));
        if (disc < 0) begin
            r.root_status = ST_NONE;
        end else if (disc == 0) begin
            r.root_status = ST_DOUBLE;
            r.root_first = r.vertex_x;
            r.root_second = r.vertex_x;
        end else begin
            rad = 128'(disc) << (2 * FB);
            s = isqrt128(rad);
            r.root_status = ST_TWO;
            r.root_first = OW'((nb - s) / two_a);
            r.root_second = OW'((nb + s) / two_a);
        end
        return r;
    endfunction

    function automatic coefs_t random_coefs();
        coefs_t w;
        int k, m;
        case ($urandom_range(0, 5))
            0, 1: w = {CW'($urandom), CW'($urandom), CW'($urandom)};
            2: begin
                // small magnitudes give all root cases often
                w.a = CW'($urandom_range(0, 40) - 20);
                w.b = CW'($urandom_range(0, 200) - 100);
                w.c = CW'($urandom_range(0, 200) - 100);
            end
            3: begin
                // double root: k*(x+m)^2
                k = $urandom_range(1, 60);
                m = $urandom_range(0, 40) - 20;
                if ($urandom_range(0, 1)) k = -k;
                w = {CW'(k), CW'(2 * k * m), CW'(k * m * m)};
            end
            4: w = {CW'($urandom_range(0, 4) - 2), CW'($urandom), CW'($urandom)};
            default: w = {CW'($urandom), CW'($urandom_range(0, 1) ? 16'h8000 : 16'h7fff),
                          CW'($urandom_range(0, 2) - 1)};
        endcase
        return w;
    endfunction

    // driver
    always @(posedge aclk) begin
        coefs_t w;
        cycles <= cycles + 1;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                solution_queue.push_back(solve_quadratic({s_coef_a, s_coef_b, s_coef_c}));
            if (!s_valid || s_ready) begin
                if (coef_queue.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    w = coef_queue.pop_front();
                    s_coef_a <= w.a;
                    s_coef_b <= w.b;
                    s_coef_c <= w.c;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        result_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_solved++;
                if (solution_queue.size() == 0) begin
                    $error("result word with nothing expected");
                    n_errors++;
                end else begin
                    e = solution_queue.pop_front();
                    if (m_vertex_x !== e.vertex_x) begin
                        $error("vertex_x exp %0d got %0d", $signed(e.vertex_x),
                               $signed(m_vertex_x));
                        n_errors++;
                    end
                    if (m_vertex_y !== e.vertex_y) begin
                        $error("vertex_y exp %0d got %0d", $signed(e.vertex_y),
                               $signed(m_vertex_y));
                        n_errors++;
                    end
                    if (m_root_status !== e.root_status) begin
                        $error("root_status exp %0d got %0d", e.root_status, m_root_status);
                        n_errors++;
                    end
                    if (m_root_first !== e.root_first) begin
                        $error("root_first exp %0d got %0d", $signed(e.root_first),
                               $signed(m_root_first));
                        n_errors++;
                    end
                    if (m_root_second !== e.root_second) begin
                        $error("root_second exp %0d got %0d", $signed(e.root_second),
                               $signed(m_root_second));
                        n_errors++;
                    end
                end
            end
            // one long hold-off so the pipeline backs up into the input
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else if (!hold_done && n_solved == 60) begin
                hold_done <= 1'b1;
                hold_left <= 400;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        coef_queue.push_back({16'sd0, 16'sd5, 16'sd7});        // leading zero
        coef_queue.push_back({16'h0000, 16'h8000, 16'h7fff});
        coef_queue.push_back({16'sd1, 16'sd0, 16'sd1});         // no real roots
        coef_queue.push_back({16'sd1, 16'sd2, 16'sd1});         // double root
        coef_queue.push_back({-16'sd3, 16'sd12, -16'sd12});
        coef_queue.push_back({16'sd1, -16'sd3, 16'sd2});        // two roots
        coef_queue.push_back({-16'sd2, 16'sd5, 16'sd3});
        coef_queue.push_back({16'h8000, 16'h8000, 16'h8000});
        coef_queue.push_back({16'h7fff, 16'h7fff, 16'h7fff});
        coef_queue.push_back({16'h8000, 16'h7fff, 16'h7fff});
        coef_queue.push_back({16'h7fff, 16'h8000, 16'h8000});
        coef_queue.push_back({16'sd1, 16'h8000, 16'h8000});
        coef_queue.push_back({16'sd1, 16'h8000, 16'h7fff});
        coef_queue.push_back({-16'sd1, 16'h7fff, 16'h7fff});
        coef_queue.push_back({16'hffff, 16'h0000, 16'h0000});
        coef_queue.push_back({16'sd1, 16'sd0, 16'sd0});
        coef_queue.push_back({16'sd7, 16'sd1, 16'sd0});
        coef_queue.push_back({16'sd3, 16'sd1, 16'h8000});

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 46; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 46; end
                default: begin src_idle_pct = 6; snk_stall_pct = 6; end
            endcase
            for (int i = 0; i < 250; i++)
                coef_queue.push_back(random_coefs());
            while (coef_queue.size() > 0) @(posedge aclk);
        end

        while (s_valid || solution_queue.size() > 0 || hold_left > 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (n_errors == 0 && solution_queue.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
